### rtl/core/wgamfm_pkg.sv
package wgamfm_pkg;

	localparam logic [2:0] WAVE_SINE     = 3'd0;
	localparam logic [2:0] WAVE_SAW      = 3'd1;
	localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
	localparam logic [2:0] WAVE_SQUARE   = 3'd3;
	localparam logic [2:0] WAVE_NOISE    = 3'd4;

	localparam logic [1:0] MOD_NONE = 2'd0;
	localparam logic [1:0] MOD_AM   = 2'd1;
	localparam logic [1:0] MOD_FM   = 2'd2;
	localparam logic [1:0] MOD_OFF  = 2'd3;

	localparam logic [2:0] REG_WAVE_TYPE      = 3'd0;
	localparam logic [2:0] REG_MODULATION     = 3'd1;
	localparam logic [2:0] REG_AMPLITUDE      = 3'd2;
	localparam logic [2:0] REG_CARRIER_STEP   = 3'd3;
	localparam logic [2:0] REG_MODULATOR_STEP = 3'd4;
	localparam logic [2:0] REG_CHANNEL_COUNT  = 3'd5;
	localparam logic [2:0] REG_FM_DEPTH       = 3'd6;

	localparam logic [31:0] NOISE_TAPS  = 32'h8020_0003;
	localparam logic [31:0] NOISE_SEED  = 32'd1;
	localparam logic [31:0] QUARTER_CYC = 32'h4000_0000;

	localparam longint PC1 = 1686629713;
	localparam longint PC3 = 693598668;
	localparam longint PC5 = 85569306;
	localparam longint PC7 = 5026996;
	localparam longint PC9 = 172272;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RMUL,
		ST_RLOAD_C,
		ST_RLOAD_M,
		ST_ADV,
		ST_LOOK,
		ST_MUL1,
		ST_PHASE,
		ST_MUL2,
		ST_SAT,
		ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_RMUL_C,
		OP_RLOAD_C,
		OP_RLOAD_M,
		OP_ADV,
		OP_LOOK,
		OP_MUL1,
		OP_PHASE,
		OP_MUL2,
		OP_SAT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic capture;
	} cmd_t;

	function automatic longint msh(input longint a, input longint b, input int sh);
		logic neg;
		longint unsigned ua;
		longint unsigned ub;
		longint unsigned r;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? longint'(-a) : a;
		ub = (b < 0) ? longint'(-b) : b;
		r = (ua * ub + (64'd1 << (sh - 1))) >> sh;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic [14:0] sine_entry(input int unsigned xi, input int unsigned bits);
		longint x;
		longint x2;
		longint t;
		longint y;
		x = longint'(xi) << (32 - bits);
		x2 = msh(x, x, 30);
		t = PC9;
		t = msh(x2, t, 30) - PC7;
		t = msh(x2, t, 30) + PC5;
		t = msh(x2, t, 30) - PC3;
		t = msh(x2, t, 30) + PC1;
		y = msh(msh(x, t, 30), 1, 15);
		if (y > 32767) begin
			y = 32767;
		end
		return y[14:0];
	endfunction

endpackage

### rtl/core/waveform_generator_am_fm_core.sv
// channel   dir  width              content
// s_axis    in   tdata 96, tuser 1  restart or frame item
// m_axis    out  tdata 16, tlast    one sample beat per channel
// apb       in   32-bit data        seven registers at 4-byte steps
// restart item: after accept, runs the RMUL, RLOAD_C and RLOAD_M states, then returns to idle for the next item
// frame item: ADV, LOOK, MUL1, PHASE (fm only), MUL2 (am or fm), SAT, then n_eff output beats
// frame compute steps run on one shared multiplier and the sine table
// reset clears phases, sets the noise register to its seed and registers to defaults
// input is not taken during a restart item, while a frame is computed or while its beats wait on m_tready
module waveform_generator_am_fm_core #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int MAX_CHANNELS    = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // sample_index, carrier_offset, modulator_offset
	input  logic [0:0]  s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // sample
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = $clog2(MAX_CHANNELS + 1);

	logic [2:0]  wave_type_q;
	logic [1:0]  modulation_q;
	logic [15:0] amplitude_q;
	logic [31:0] carrier_step_q, modulator_step_q;
	logic [3:0]  channel_count_q;
	logic [19:0] fm_depth_q;
	logic [2:0]  reg_idx;
	logic        wr;
	logic [CW-1:0] n_eff;
	wgamfm_pkg::cmd_t cmd;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr      = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_type_q      <= '0;
			modulation_q     <= '0;
			amplitude_q      <= 16'd32768;
			carrier_step_q   <= '0;
			modulator_step_q <= 32'd89478;
			channel_count_q  <= 4'd2;
			fm_depth_q       <= 20'd312908;
		end else if (wr) begin
			case (reg_idx)
				wgamfm_pkg::REG_WAVE_TYPE:      wave_type_q      <= pwdata[2:0];
				wgamfm_pkg::REG_MODULATION:     modulation_q     <= pwdata[1:0];
				wgamfm_pkg::REG_AMPLITUDE:      amplitude_q      <= pwdata[15:0];
				wgamfm_pkg::REG_CARRIER_STEP:   carrier_step_q   <= pwdata;
				wgamfm_pkg::REG_MODULATOR_STEP: modulator_step_q <= pwdata;
				wgamfm_pkg::REG_CHANNEL_COUNT:  channel_count_q  <= pwdata[3:0];
				wgamfm_pkg::REG_FM_DEPTH:       fm_depth_q       <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			wgamfm_pkg::REG_WAVE_TYPE:      prdata = {29'd0, wave_type_q};
			wgamfm_pkg::REG_MODULATION:     prdata = {30'd0, modulation_q};
			wgamfm_pkg::REG_AMPLITUDE:      prdata = {16'd0, amplitude_q};
			wgamfm_pkg::REG_CARRIER_STEP:   prdata = carrier_step_q;
			wgamfm_pkg::REG_MODULATOR_STEP: prdata = modulator_step_q;
			wgamfm_pkg::REG_CHANNEL_COUNT:  prdata = {28'd0, channel_count_q};
			wgamfm_pkg::REG_FM_DEPTH:       prdata = {12'd0, fm_depth_q};
			default:                        prdata = '0;
		endcase
	end

	always_comb begin
		if (channel_count_q == 4'd0) begin
			n_eff = CW'(1);
		end else if (32'(channel_count_q) > 32'(MAX_CHANNELS)) begin
			n_eff = CW'(MAX_CHANNELS);
		end else begin
			n_eff = CW'(channel_count_q);
		end
	end

	wgamfm_ctrl #(
		.CW(CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_func     (s_tuser[0]),
		.s_tready   (s_tready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tlast    (m_tlast),
		.modulation (modulation_q),
		.n_eff      (n_eff),
		.cmd        (cmd)
	);

	wgamfm_dp #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sample_index     (s_tdata[31:0]),
		.carrier_offset   (s_tdata[63:32]),
		.modulator_offset (s_tdata[95:64]),
		.wave_type        (wave_type_q),
		.modulation       (modulation_q),
		.amplitude        (amplitude_q),
		.carrier_step     (carrier_step_q),
		.modulator_step   (modulator_step_q),
		.fm_depth         (fm_depth_q),
		.sample           (m_tdata)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input taken while output beats pending");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("output continued after last beat");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !m_tvalid)
		else $error("accepted item not processed");

endmodule

### rtl/core/wgamfm_ctrl.sv
module wgamfm_ctrl #(
	parameter int CW = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_func,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic                m_tlast,
	input  logic [1:0]          modulation,
	input  logic [CW-1:0]       n_eff,
	output wgamfm_pkg::cmd_t    cmd
);

	wgamfm_pkg::state_t state_q, state_nxt;
	logic [CW-1:0] cnt_q;
	logic in_beat, out_beat, is_last;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;
	assign is_last  = (cnt_q == n_eff - CW'(1));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			wgamfm_pkg::ST_IDLE: begin
				if (in_beat) begin
					state_nxt = s_func ? wgamfm_pkg::ST_ADV : wgamfm_pkg::ST_RMUL;
				end
			end
			wgamfm_pkg::ST_RMUL:    state_nxt = wgamfm_pkg::ST_RLOAD_C;
			wgamfm_pkg::ST_RLOAD_C: state_nxt = wgamfm_pkg::ST_RLOAD_M;
			wgamfm_pkg::ST_RLOAD_M: state_nxt = wgamfm_pkg::ST_IDLE;
			wgamfm_pkg::ST_ADV:     state_nxt = wgamfm_pkg::ST_LOOK;
			wgamfm_pkg::ST_LOOK:    state_nxt = wgamfm_pkg::ST_MUL1;
			wgamfm_pkg::ST_MUL1: begin
				case (modulation)
					wgamfm_pkg::MOD_AM: state_nxt = wgamfm_pkg::ST_MUL2;
					wgamfm_pkg::MOD_FM: state_nxt = wgamfm_pkg::ST_PHASE;
					default:            state_nxt = wgamfm_pkg::ST_SAT;
				endcase
			end
			wgamfm_pkg::ST_PHASE:   state_nxt = wgamfm_pkg::ST_MUL2;
			wgamfm_pkg::ST_MUL2:    state_nxt = wgamfm_pkg::ST_SAT;
			wgamfm_pkg::ST_SAT:     state_nxt = wgamfm_pkg::ST_EMIT;
			wgamfm_pkg::ST_EMIT: begin
				if (out_beat && is_last) begin
					state_nxt = wgamfm_pkg::ST_IDLE;
				end
			end
			default: state_nxt = wgamfm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		m_tvalid    = 1'b0;
		m_tlast     = 1'b0;
		cmd.op      = wgamfm_pkg::OP_NONE;
		cmd.capture = 1'b0;
		case (state_q)
			wgamfm_pkg::ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			wgamfm_pkg::ST_RMUL:    cmd.op = wgamfm_pkg::OP_RMUL_C;
			wgamfm_pkg::ST_RLOAD_C: cmd.op = wgamfm_pkg::OP_RLOAD_C;
			wgamfm_pkg::ST_RLOAD_M: cmd.op = wgamfm_pkg::OP_RLOAD_M;
			wgamfm_pkg::ST_ADV:     cmd.op = wgamfm_pkg::OP_ADV;
			wgamfm_pkg::ST_LOOK:    cmd.op = wgamfm_pkg::OP_LOOK;
			wgamfm_pkg::ST_MUL1:    cmd.op = wgamfm_pkg::OP_MUL1;
			wgamfm_pkg::ST_PHASE:   cmd.op = wgamfm_pkg::OP_PHASE;
			wgamfm_pkg::ST_MUL2:    cmd.op = wgamfm_pkg::OP_MUL2;
			wgamfm_pkg::ST_SAT:     cmd.op = wgamfm_pkg::OP_SAT;
			wgamfm_pkg::ST_EMIT: begin
				m_tvalid = 1'b1;
				m_tlast  = is_last;
			end
			default: cmd.op = wgamfm_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wgamfm_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == wgamfm_pkg::ST_SAT) begin
				cnt_q <= '0;
			end else if (out_beat) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

endmodule

### rtl/core/wgamfm_dp.sv
module wgamfm_dp #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wgamfm_pkg::cmd_t    cmd,
	input  logic [31:0]         sample_index,
	input  logic [31:0]         carrier_offset,
	input  logic [31:0]         modulator_offset,
	input  logic [2:0]          wave_type,
	input  logic [1:0]          modulation,
	input  logic [15:0]         amplitude,
	input  logic [31:0]         carrier_step,
	input  logic [31:0]         modulator_step,
	input  logic [19:0]         fm_depth,
	output logic [15:0]         sample
);

	localparam int QB = SINE_TABLE_BITS - 2;
	localparam int QN = 1 << QB;

	logic [14:0] sin_tab [QN+1];

	for (genvar i = 0; i <= QN; i++) begin : g_tab
		assign sin_tab[i] = wgamfm_pkg::sine_entry(i, SINE_TABLE_BITS);
	end

	function automatic logic signed [16:0] sine_q15(input logic [31:0] p);
		logic [QB-1:0] k;
		logic [QB:0]   xi;
		logic [14:0]   m;
		k  = p[29 -: QB];
		xi = p[30] ? ((QB+1)'(QN) - {1'b0, k}) : {1'b0, k};
		m  = sin_tab[xi];
		return p[31] ? -$signed({2'b00, m}) : $signed({2'b00, m});
	endfunction

	logic [31:0] idx_q, coff_q, moff_q, rmul_q;
	logic [31:0] cph_q, mph_q, noise_q;
	logic signed [16:0] wave_q, sm_q;
	logic signed [37:0] res_q;
	logic [15:0] sample_q;

	logic signed [16:0] wave_nxt;
	logic [15:0] u;
	logic signed [21:0] opa, opb;
	logic sh15;
	logic [21:0] mag_a, mag_b;
	logic [43:0] prod, rnd;
	logic signed [37:0] mul_res;
	logic [31:0] fm_phase;

	assign u = cph_q[31:16];

	always_comb begin
		case (wave_type)
			wgamfm_pkg::WAVE_SINE:     wave_nxt = sine_q15(cph_q);
			wgamfm_pkg::WAVE_SAW:      wave_nxt = $signed({1'b0, u}) - 17'sd32768;
			wgamfm_pkg::WAVE_TRIANGLE: wave_nxt = !u[15] ? ($signed({u, 1'b0}) - 17'sd32768)
				: (17'sd32768 - $signed({1'b0, u[14:0], 1'b0}));
			wgamfm_pkg::WAVE_SQUARE:   wave_nxt = !u[15] ? 17'sd32768 : -17'sd32768;
			wgamfm_pkg::WAVE_NOISE:    wave_nxt = 17'($signed(noise_q[31:16]));
			default:                   wave_nxt = '0;
		endcase
	end

	// shared signed multiplier, rounds half away from zero
	always_comb begin
		opa  = 22'($signed({1'b0, amplitude}));
		opb  = 22'(wave_q);
		sh15 = 1'b1;
		if (cmd.op == wgamfm_pkg::OP_MUL1) begin
			case (modulation)
				wgamfm_pkg::MOD_AM: opb = 22'(sm_q);
				wgamfm_pkg::MOD_FM: begin
					opa  = 22'($signed({1'b0, fm_depth}));
					opb  = 22'(sm_q);
					sh15 = 1'b0;
				end
				default: opb = 22'(wave_q);
			endcase
		end else if (modulation == wgamfm_pkg::MOD_AM) begin
			opa = res_q[21:0];
		end
		mag_a = opa[21] ? 22'(-opa) : opa;
		mag_b = opb[21] ? 22'(-opb) : opb;
		prod  = 44'(mag_a) * 44'(mag_b);
		rnd   = sh15 ? ((prod + 44'd16384) >> 15) : ((prod + 44'd1) >> 1);
		mul_res = (opa[21] != opb[21]) ? -$signed(rnd[37:0]) : $signed(rnd[37:0]);
	end

	assign fm_phase = cph_q + {res_q[29:0], 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cph_q   <= '0;
			mph_q   <= '0;
			noise_q <= wgamfm_pkg::NOISE_SEED;
		end else begin
			case (cmd.op)
				wgamfm_pkg::OP_RLOAD_C: cph_q <= coff_q + rmul_q;
				wgamfm_pkg::OP_RLOAD_M: mph_q <= moff_q + rmul_q;
				wgamfm_pkg::OP_ADV: begin
					cph_q <= cph_q + carrier_step;
					mph_q <= mph_q + modulator_step;
					if (wave_type == wgamfm_pkg::WAVE_NOISE && !modulation[1]) begin
						noise_q <= (noise_q >> 1) ^ (noise_q[0] ? wgamfm_pkg::NOISE_TAPS : '0);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q  <= sample_index;
			coff_q <= carrier_offset;
			moff_q <= modulator_offset;
		end
		case (cmd.op)
			wgamfm_pkg::OP_RMUL_C:  rmul_q <= 32'(idx_q * carrier_step);
			wgamfm_pkg::OP_RLOAD_C: rmul_q <= 32'(idx_q * modulator_step);
			wgamfm_pkg::OP_LOOK: begin
				wave_q <= wave_nxt;
				sm_q   <= sine_q15(mph_q + ((modulation == wgamfm_pkg::MOD_FM)
					? wgamfm_pkg::QUARTER_CYC : '0));
			end
			wgamfm_pkg::OP_MUL1,
			wgamfm_pkg::OP_MUL2:    res_q <= mul_res;
			wgamfm_pkg::OP_PHASE:   wave_q <= sine_q15(fm_phase);
			wgamfm_pkg::OP_SAT: begin
				if (modulation == wgamfm_pkg::MOD_OFF) begin
					sample_q <= '0;
				end else if (res_q > 38'sd32767) begin
					sample_q <= 16'h7fff;
				end else if (res_q < -38'sd32768) begin
					sample_q <= 16'h8000;
				end else begin
					sample_q <= res_q[15:0];
				end
			end
			default: ;
		endcase
	end

	assign sample = sample_q;

endmodule
